// ===== sv/rss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg
// types, widths and codes shared by the rope stroke stabilizer modules
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int POS_W    = 16;              // cursor and brush coordinates
    localparam int MAG_W    = POS_W;           // |cursor - brush| per axis
    localparam int RAD_W    = 10;              // rope radius
    localparam int FRAC_W   = 8;               // fraction bits of the distance
    localparam int D2_W     = 2 * MAG_W + 1;   // dx*dx + dy*dy
    localparam int ROOT_W   = 25;              // floor(sqrt(d2 * 2^16))
    localparam int V_W      = 2 * ROOT_W;      // square root radicand
    localparam int REM_W    = ROOT_W + 2;      // square root remainder
    localparam int NUM_W    = ROOT_W;          // multiplier operand a
    localparam int PROD_W   = NUM_W + MAG_W;   // multiplier product
    localparam int NUMER_W  = PROD_W + 1;      // divider dividend
    localparam int DEN_W    = ROOT_W + 1;      // divider divisor
    localparam int QUO_W    = MAG_W;           // divider quotient
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int MUL_CNT_W  = 4;
    localparam int SQRT_CNT_W = 5;
    localparam int DIV_CNT_W  = 4;
    localparam logic [MUL_CNT_W-1:0]  MUL_LAST  = MUL_CNT_W'(MAG_W - 1);
    localparam logic [SQRT_CNT_W-1:0] SQRT_LAST = SQRT_CNT_W'(ROOT_W - 1);
    localparam logic [DIV_CNT_W-1:0]  DIV_LAST  = DIV_CNT_W'(QUO_W - 1);

    // event codes
    localparam logic [1:0] CMD_PRESS   = 2'd0;
    localparam logic [1:0] CMD_MOVE    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // register index, taken from paddr above the byte lanes
    localparam logic [PADDR_W-3:0] REG_ROPE_RADIUS = '0;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    select_tool_active;
        logic                    button_held;
    } t_in_word;

    typedef struct packed {
        logic                    rewrite;
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
    } t_out_word;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ_X = 7'b0000010,
        S_SQ_Y = 7'b0000100,
        S_SQRT = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

endpackage

// ===== sv/rss_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_mul
// shift-add multiplier, one bit of the b operand per cycle
// ----------------------------------------------------------------------------
module rss_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rss_pkg::NUM_W-1:0]   i_a,
    input  logic [rss_pkg::MAG_W-1:0]   i_b,
    output logic                        o_done,
    output logic [rss_pkg::PROD_W-1:0]  o_prod
);

    logic [rss_pkg::NUM_W-1:0]     r_a;
    logic [rss_pkg::PROD_W-1:0]    r_acc;
    logic [rss_pkg::PROD_W-1:0]    n_acc;
    logic [rss_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [rss_pkg::NUM_W:0]       w_sum;

    // b sits in the low part of the accumulator and shifts out as the sum grows
    always_comb begin
        w_sum = {1'b0, r_acc[rss_pkg::PROD_W-1:rss_pkg::MAG_W]}
              + (r_acc[0] ? {1'b0, r_a} : '0);
        n_acc = {w_sum, r_acc[rss_pkg::MAG_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rss_pkg::MUL_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= {{rss_pkg::NUM_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== sv/rss_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_isqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module rss_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rss_pkg::V_W-1:0]     i_v,
    output logic                        o_done,
    output logic [rss_pkg::ROOT_W-1:0]  o_root,
    output logic                        o_rem_zero
);

    logic [rss_pkg::V_W-1:0]        r_v;
    logic [rss_pkg::REM_W-1:0]      r_rem;
    logic [rss_pkg::ROOT_W-1:0]     r_root;
    logic [rss_pkg::SQRT_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [rss_pkg::REM_W+1:0]      w_cand;
    logic [rss_pkg::REM_W+1:0]      w_trial;
    logic [rss_pkg::REM_W+1:0]      w_diff;
    logic                           w_ge;

    // bring down the next two radicand bits and try 4*root + 1
    always_comb begin
        w_cand  = {r_rem, r_v[rss_pkg::V_W-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        w_ge    = (w_cand >= w_trial);
        w_diff  = w_cand - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rss_pkg::SQRT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_v;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= {r_v[rss_pkg::V_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[rss_pkg::REM_W-1:0] : w_cand[rss_pkg::REM_W-1:0];
            r_root <= {r_root[rss_pkg::ROOT_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_root     = r_root;
    assign o_rem_zero = (r_rem == '0);

endmodule

// ===== sv/rss_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rss_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rss_pkg::NUMER_W-1:0]  i_numer,
    input  logic [rss_pkg::DEN_W-1:0]    i_den,
    output logic                         o_done,
    output logic [rss_pkg::QUO_W-1:0]    o_quo
);

    logic [rss_pkg::DEN_W-1:0]     r_den;
    logic [rss_pkg::DEN_W-1:0]     r_rem;
    logic [rss_pkg::QUO_W-1:0]     r_low;
    logic [rss_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [rss_pkg::DEN_W:0]       w_cand;
    logic [rss_pkg::DEN_W:0]       w_diff;
    logic                          w_ge;

    // quotient is known to fit, so the upper dividend part starts below the divisor
    always_comb begin
        w_cand = {r_rem, r_low[rss_pkg::QUO_W-1]};
        w_ge   = (w_cand >= {1'b0, r_den});
        w_diff = w_cand - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rss_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_numer[rss_pkg::NUMER_W-1:rss_pkg::QUO_W];
            r_low <= i_numer[rss_pkg::QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[rss_pkg::DEN_W-1:0] : w_cand[rss_pkg::DEN_W-1:0];
            r_low <= {r_low[rss_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_low;

endmodule

// ===== sv/rope_stroke_stabilizer.sv =====
`timescale 1ns / 1ps
// a dragging move goes from acceptance to its word at the output through these steps:
//   two 16-step squares, a 25-step square root, then per axis a 16-step multiply and a
//   16-step divide, each unit adding a start and a hand-back to its steps
// a move that leaves the brush in place ends after the square root; other events use no unit
// one event at a time: the next is taken once the result has entered the output register
// synchronous active-low reset: no stroke, brush at the origin, radius zero (block passive)
// ----------------------------------------------------------------------------
// rope_stroke_stabilizer
// lazy brush: drags a brush point on a rope behind the cursor during a stroke
// ----------------------------------------------------------------------------
module rope_stroke_stabilizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  rss_pkg::t_in_word             i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output rss_pkg::t_out_word            o_out_data,
    input  logic                          i_out_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rss_pkg::PADDR_W-1:0]   paddr,
    input  logic [rss_pkg::PDATA_W-1:0]   pwdata,
    output logic [rss_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    rss_pkg::t_state                   r_state, n_state;
    logic [rss_pkg::RAD_W-1:0]         r_radius, n_radius;
    logic                              r_stroking, n_stroking;
    logic signed [rss_pkg::POS_W-1:0]  r_brush_x, n_brush_x;
    logic signed [rss_pkg::POS_W-1:0]  r_brush_y, n_brush_y;
    logic                              r_mul_start, n_mul_start;
    logic                              r_sqrt_start, n_sqrt_start;
    logic                              r_div_start, n_div_start;
    logic                              r_out_valid, n_out_valid;
    rss_pkg::t_out_word                r_out, n_out;
    logic [rss_pkg::MAG_W-1:0]         r_mag_x, n_mag_x;
    logic [rss_pkg::MAG_W-1:0]         r_mag_y, n_mag_y;
    logic                              r_neg_x, n_neg_x;
    logic                              r_neg_y, n_neg_y;
    logic [rss_pkg::D2_W-1:0]          r_d2, n_d2;
    logic [rss_pkg::ROOT_W-1:0]        r_dq, n_dq;
    logic [rss_pkg::NUM_W-1:0]         r_num, n_num;
    logic [rss_pkg::PROD_W-1:0]        r_prod, n_prod;
    logic                              r_axis, n_axis;
    logic                              r_rw, n_rw;

    logic [rss_pkg::POS_W:0]           w_dx, w_dy, w_ndx, w_ndy;
    logic [rss_pkg::NUM_W-1:0]         w_mul_a;
    logic [rss_pkg::MAG_W-1:0]         w_mul_b;
    logic                              w_mul_done;
    logic [rss_pkg::PROD_W-1:0]        w_prod;
    logic [rss_pkg::V_W-1:0]           w_v;
    logic                              w_sqrt_done;
    logic [rss_pkg::ROOT_W-1:0]        w_root;
    logic                              w_rem_zero;
    logic [rss_pkg::NUMER_W-1:0]       w_numer;
    logic [rss_pkg::DEN_W-1:0]         w_den;
    logic                              w_div_done;
    logic [rss_pkg::QUO_W-1:0]         w_quo;
    logic [rss_pkg::ROOT_W-1:0]        w_thr;
    logic                              w_stay;
    logic [rss_pkg::POS_W:0]           w_step;
    logic [rss_pkg::POS_W:0]           w_base;
    logic [rss_pkg::POS_W:0]           w_new;
    logic                              w_neg;
    logic                              w_cfg_wr;

    // ---- datapath operands --------------------------------------------------

    always_comb begin
        w_dx  = {i_in_data.pos_x[rss_pkg::POS_W-1], i_in_data.pos_x}
              - {r_brush_x[rss_pkg::POS_W-1], r_brush_x};
        w_dy  = {i_in_data.pos_y[rss_pkg::POS_W-1], i_in_data.pos_y}
              - {r_brush_y[rss_pkg::POS_W-1], r_brush_y};
        w_ndx = -w_dx;
        w_ndy = -w_dy;

        case (r_state)
            rss_pkg::S_SQ_Y: begin
                w_mul_a = rss_pkg::NUM_W'(r_mag_y);
                w_mul_b = r_mag_y;
            end
            rss_pkg::S_MUL: begin
                w_mul_a = r_num;
                w_mul_b = r_axis ? r_mag_y : r_mag_x;
            end
            default: begin
                w_mul_a = rss_pkg::NUM_W'(r_mag_x);
                w_mul_b = r_mag_x;
            end
        endcase

        // radicand is d2 in q16, root comes back in q8
        w_v     = {{(rss_pkg::V_W - rss_pkg::D2_W - 2 * rss_pkg::FRAC_W){1'b0}},
                   r_d2, {(2 * rss_pkg::FRAC_W){1'b0}}};
        w_thr   = {{(rss_pkg::ROOT_W - rss_pkg::RAD_W - rss_pkg::FRAC_W){1'b0}},
                   r_radius, {rss_pkg::FRAC_W{1'b0}}};
        // stay when d2 <= r*r: exact via root and remainder of the scaled radicand
        w_stay  = (w_root < w_thr) || ((w_root == w_thr) && w_rem_zero);

        // rounding half away from zero: (2*|d|*num + dq) / (2*dq)
        w_numer = {r_prod, 1'b0} + rss_pkg::NUMER_W'(r_dq);
        w_den   = {r_dq, 1'b0};

        w_neg   = r_axis ? r_neg_y : r_neg_x;
        w_base  = r_axis ? {r_brush_y[rss_pkg::POS_W-1], r_brush_y}
                         : {r_brush_x[rss_pkg::POS_W-1], r_brush_x};
        w_step  = {1'b0, w_quo};
        w_new   = w_neg ? (w_base - w_step) : (w_base + w_step);
    end

    rss_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    rss_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_start),
        .i_v        (w_v),
        .o_done     (w_sqrt_done),
        .o_root     (w_root),
        .o_rem_zero (w_rem_zero)
    );

    rss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_numer (w_numer),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // ---- configuration port -------------------------------------------------

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite
                   && (paddr[rss_pkg::PADDR_W-1:2] == rss_pkg::REG_ROPE_RADIUS);

    always_comb begin
        if (paddr[rss_pkg::PADDR_W-1:2] == rss_pkg::REG_ROPE_RADIUS) begin
            prdata = rss_pkg::PDATA_W'(r_radius);
        end else begin
            prdata = '0;
        end
    end

    // ---- sequencer ----------------------------------------------------------

    always_comb begin
        n_state      = r_state;
        n_radius     = w_cfg_wr ? pwdata[rss_pkg::RAD_W-1:0] : r_radius;
        n_stroking   = r_stroking;
        n_brush_x    = r_brush_x;
        n_brush_y    = r_brush_y;
        n_mul_start  = 1'b0;
        n_sqrt_start = 1'b0;
        n_div_start  = 1'b0;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        n_mag_x      = r_mag_x;
        n_mag_y      = r_mag_y;
        n_neg_x      = r_neg_x;
        n_neg_y      = r_neg_y;
        n_d2         = r_d2;
        n_dq         = r_dq;
        n_num        = r_num;
        n_prod       = r_prod;
        n_axis       = r_axis;
        n_rw         = r_rw;

        case (r_state)
            rss_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_rw    = 1'b0;
                    n_state = rss_pkg::S_DONE;
                    if (r_radius != '0) begin
                        case (i_in_data.cmd)
                            rss_pkg::CMD_PRESS: begin
                                if (i_in_data.select_tool_active) begin
                                    n_stroking = 1'b0;
                                end else begin
                                    n_stroking = 1'b1;
                                    n_brush_x  = i_in_data.pos_x;
                                    n_brush_y  = i_in_data.pos_y;
                                end
                            end
                            rss_pkg::CMD_MOVE: begin
                                if (r_stroking && !i_in_data.button_held) begin
                                    n_stroking = 1'b0;
                                end else if (r_stroking) begin
                                    n_neg_x     = w_dx[rss_pkg::POS_W];
                                    n_neg_y     = w_dy[rss_pkg::POS_W];
                                    n_mag_x     = w_dx[rss_pkg::POS_W] ?
                                                  w_ndx[rss_pkg::MAG_W-1:0] :
                                                  w_dx[rss_pkg::MAG_W-1:0];
                                    n_mag_y     = w_dy[rss_pkg::POS_W] ?
                                                  w_ndy[rss_pkg::MAG_W-1:0] :
                                                  w_dy[rss_pkg::MAG_W-1:0];
                                    n_mul_start = 1'b1;
                                    n_state     = rss_pkg::S_SQ_X;
                                end
                            end
                            rss_pkg::CMD_RELEASE: begin
                                if (r_stroking) begin
                                    n_rw       = 1'b1;
                                    n_stroking = 1'b0;
                                end
                            end
                            default: begin
                                n_rw = 1'b0;
                            end
                        endcase
                    end
                end
            end
            rss_pkg::S_SQ_X: begin
                if (w_mul_done) begin
                    n_d2        = w_prod[rss_pkg::D2_W-1:0];
                    n_mul_start = 1'b1;
                    n_state     = rss_pkg::S_SQ_Y;
                end
            end
            rss_pkg::S_SQ_Y: begin
                if (w_mul_done) begin
                    n_d2         = r_d2 + w_prod[rss_pkg::D2_W-1:0];
                    n_sqrt_start = 1'b1;
                    n_state      = rss_pkg::S_SQRT;
                end
            end
            rss_pkg::S_SQRT: begin
                if (w_sqrt_done) begin
                    n_rw = 1'b1;
                    if (w_stay) begin
                        n_state = rss_pkg::S_DONE;
                    end else begin
                        n_dq        = w_root;
                        n_num       = w_root - w_thr;
                        n_axis      = 1'b0;
                        n_mul_start = 1'b1;
                        n_state     = rss_pkg::S_MUL;
                    end
                end
            end
            rss_pkg::S_MUL: begin
                if (w_mul_done) begin
                    n_prod      = w_prod;
                    n_div_start = 1'b1;
                    n_state     = rss_pkg::S_DIV;
                end
            end
            rss_pkg::S_DIV: begin
                if (w_div_done) begin
                    if (r_axis) begin
                        n_brush_y = w_new[rss_pkg::POS_W-1:0];
                        n_state   = rss_pkg::S_DONE;
                    end else begin
                        n_brush_x   = w_new[rss_pkg::POS_W-1:0];
                        n_axis      = 1'b1;
                        n_mul_start = 1'b1;
                        n_state     = rss_pkg::S_MUL;
                    end
                end
            end
            rss_pkg::S_DONE: begin
                // hand the word over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out.rewrite = r_rw;
                    n_out.out_x   = r_rw ? r_brush_x : '0;
                    n_out.out_y   = r_rw ? r_brush_y : '0;
                    n_state       = rss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rss_pkg::S_IDLE;
            r_radius     <= '0;
            r_stroking   <= 1'b0;
            r_brush_x    <= '0;
            r_brush_y    <= '0;
            r_mul_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_radius     <= n_radius;
            r_stroking   <= n_stroking;
            r_brush_x    <= n_brush_x;
            r_brush_y    <= n_brush_y;
            r_mul_start  <= n_mul_start;
            r_sqrt_start <= n_sqrt_start;
            r_div_start  <= n_div_start;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_mag_x <= n_mag_x;
        r_mag_y <= n_mag_y;
        r_neg_x <= n_neg_x;
        r_neg_y <= n_neg_y;
        r_d2    <= n_d2;
        r_dq    <= n_dq;
        r_num   <= n_num;
        r_prod  <= n_prod;
        r_axis  <= n_axis;
        r_rw    <= n_rw;
    end

    assign o_in_stall  = (r_state != rss_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
